// ----- design/etbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etbc_pkg
// Shared types and constants of the explosion trend bar colorizer: field
// widths, register indexes and reset values, trend classes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package etbc_pkg;

    // Field widths.
    localparam int CLOSE_W   = 24;
    localparam int AVG_W     = 40;
    localparam int ALPHA_W   = 16;
    localparam int DIVISOR_W = 24;
    localparam int SQRT_W    = 48;
    localparam int ROOT_W    = 24;
    localparam int COLOR_W   = 24;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_COEFS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_BODY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UP_COLORS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_COLORS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WEAK_COLORS = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_SENSITIVITY = 16'd150;
    localparam logic [31:0] RST_EMA_COEFS   = 32'd209524834;
    localparam logic [6:0]  RST_CHANNEL_LEN = 7'd20;
    localparam logic [11:0] RST_BAND_MULT   = 12'd512;
    localparam logic [15:0] RST_TOP_BODY    = 16'd80;
    localparam logic [47:0] RST_UP_COLORS   = 48'd1095216725760;
    localparam logic [47:0] RST_DOWN_COLORS = 48'd280375481794560;
    localparam logic [47:0] RST_WEAK_COLORS = 48'd88133402644520;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

    // Trend classes.
    typedef enum logic [2:0] {
        TC_NONE        = 3'd0,
        TC_UP_WEAK     = 3'd1,
        TC_UP_STRONG   = 3'd2,
        TC_DOWN_WEAK   = 3'd3,
        TC_DOWN_STRONG = 3'd4
    } trend_class_t;

    // Datapath operations, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_EMA_F_MUL,
        OP_EMA_F_ADD,
        OP_EMA_S_MUL,
        OP_EMA_S_ADD,
        OP_DIFF,
        OP_TREND,
        OP_WIN_RD,
        OP_WIN_SQ,
        OP_WIN_ACC,
        OP_VAR_MUL,
        OP_VAR_START,
        OP_SQRT_START,
        OP_BAND,
        OP_CLASS,
        OP_BLEND_MUL,
        OP_BLEND_START,
        OP_CH_STORE,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] chan;
    } dp_cmd_t;

    typedef struct packed {
        logic seen_lt2;
        logic win_ok;
        logic win_last;
        logic iter_done;
        logic need_blend;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/explosion_trend_bar_colorizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// explosion_trend_bar_colorizer
// Trend and explosion band bar colorizer: one closing price in, one colored
// and classified bar out from the third bar on.
// ----------------------------------------------------------------------------
// Usage:
// One close_price transaction is taken on in_valid/in_ready and processed
// alone; in_ready is high only while the block is idle. The first two bars
// update the averages and the close ring but give no result transaction;
// in_ready is high again once such a bar has passed the difference step.
// Other bars go on through the trend, band, class and push steps. Once the
// deviation window is full and the channel length is above 1, a bar also
// reads the last L closes, where L is the effective channel length, and
// runs a division and a square root on the shared iterative unit. A
// blended strong bar runs one more division per colour channel on it.
// in_ready rises in the cycle after the result is written, so a new bar
// is taken only once the result of the last one has been written.
// Results sit in an output register: a stalled receiver (out_ready low)
// holds the block only when the next result is ready to be written there.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once.
// Reset clears the averages, counters and output valid and loads the
// register defaults.
// ----------------------------------------------------------------------------
module explosion_trend_bar_colorizer #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [etbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [etbc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [etbc_pkg::CLOSE_W-1:0]    close_price,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [2:0]                      trend_class,
    output logic signed [31:0]              trend_value,
    output logic [31:0]                     explosion_band
);

    etbc_pkg::dp_cmd_t    cmd;
    etbc_pkg::dp_status_t status;

    // Sequencer.
    etbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // Arithmetic and storage.
    etbc_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .close_price    (close_price),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .trend_class    (trend_class),
        .trend_value    (trend_value),
        .explosion_band (explosion_band)
    );

endmodule

// ----- design/etbc_iter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etbc_iter
// Shared iterative unit: restoring divider, one quotient bit per cycle, and
// integer square root of the last quotient, one root bit per cycle.
// ----------------------------------------------------------------------------
module etbc_iter #(
    parameter int DVW = 62
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            sqrt_mode,
    input  logic [DVW-1:0]                  dividend,
    input  logic [etbc_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [DVW-1:0]                  quotient,
    output logic [etbc_pkg::ROOT_W-1:0]     root
);

    localparam int NW = $clog2(DVW);
    localparam int SW = etbc_pkg::SQRT_W;
    localparam int DW = etbc_pkg::DIVISOR_W;

    logic          busy_reg;
    logic          done_reg;
    logic          mode_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] last_cnt;

    logic [DW-1:0]  rem_reg;
    logic [DVW-1:0] quo_reg;
    logic [DW-1:0]  div_reg;
    logic [SW-1:0]  val_reg;
    logic [SW-1:0]  res_reg;
    logic [SW-1:0]  bit_reg;

    logic [DW:0]    trial;
    logic           trial_ge;
    logic [SW:0]    probe;
    logic           probe_ge;

    assign last_cnt = mode_reg ? NW'(etbc_pkg::ROOT_W - 1) : NW'(DVW - 1);

    // Divider step: shift in the next dividend bit and try the subtraction.
    assign trial    = {rem_reg, quo_reg[DVW-1]};
    assign trial_ge = trial >= {1'b0, div_reg};

    // Root step: compare against the partial root plus the current bit.
    assign probe    = {1'b0, res_reg} + {1'b0, bit_reg};
    assign probe_ge = {1'b0, val_reg} >= probe;

    // Sequencing of the unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            mode_reg <= sqrt_mode;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == last_cnt)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (sqrt_mode)
            begin
                val_reg <= quo_reg[SW-1:0];
                res_reg <= '0;
                bit_reg <= SW'(1) << (SW - 2);
            end
            else
            begin
                rem_reg <= '0;
                quo_reg <= dividend;
                div_reg <= divisor;
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                if (probe_ge)
                begin
                    val_reg <= val_reg - probe[SW-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                rem_reg <= trial_ge ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
                quo_reg <= {quo_reg[DVW-2:0], trial_ge};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign root     = res_reg[etbc_pkg::ROOT_W-1:0];

endmodule

// ----- design/etbc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etbc_dp
// Datapath: configuration registers, close ring, averages, trend, window
// statistics, band, classification, colour blend and the output register.
// ----------------------------------------------------------------------------
module etbc_dp #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  etbc_pkg::dp_cmd_t               cmd,
    output etbc_pkg::dp_status_t            status,
    input  logic                            cfg_write,
    input  logic [etbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [etbc_pkg::CFG_W-1:0]      cfg_data,
    input  logic [etbc_pkg::CLOSE_W-1:0]    close_price,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [2:0]                      trend_class,
    output logic signed [31:0]              trend_value,
    output logic [31:0]                     explosion_band
);

    localparam int CLW = etbc_pkg::CLOSE_W;
    localparam int AW  = etbc_pkg::AVG_W;
    localparam int PW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SMW = CLW + CW;
    localparam int SQW = 2 * CLW + CW;
    localparam int DVW = 2 * CLW + 2 * CW;
    localparam int DW  = etbc_pkg::DIVISOR_W;

    // Configuration registers.
    logic [15:0] sens_reg;
    logic [31:0] coef_reg;
    logic [6:0]  chlen_reg;
    logic [11:0] mult_reg;
    logic [15:0] top_reg;
    logic [47:0] up_reg;
    logic [47:0] down_reg;
    logic [47:0] weak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg  <= etbc_pkg::RST_SENSITIVITY;
            coef_reg  <= etbc_pkg::RST_EMA_COEFS;
            chlen_reg <= etbc_pkg::RST_CHANNEL_LEN;
            mult_reg  <= etbc_pkg::RST_BAND_MULT;
            top_reg   <= etbc_pkg::RST_TOP_BODY;
            up_reg    <= etbc_pkg::RST_UP_COLORS;
            down_reg  <= etbc_pkg::RST_DOWN_COLORS;
            weak_reg  <= etbc_pkg::RST_WEAK_COLORS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                etbc_pkg::REG_SENSITIVITY: sens_reg  <= cfg_data[15:0];
                etbc_pkg::REG_EMA_COEFS:   coef_reg  <= cfg_data[31:0];
                etbc_pkg::REG_CHANNEL_LEN: chlen_reg <= cfg_data[6:0];
                etbc_pkg::REG_BAND_MULT:   mult_reg  <= cfg_data[11:0];
                etbc_pkg::REG_TOP_BODY:    top_reg   <= cfg_data[15:0];
                etbc_pkg::REG_UP_COLORS:   up_reg    <= cfg_data;
                etbc_pkg::REG_DOWN_COLORS: down_reg  <= cfg_data;
                etbc_pkg::REG_WEAK_COLORS: weak_reg  <= cfg_data;
                default:                   sens_reg  <= sens_reg;
            endcase
        end
    end

    // Effective window length, limited to the ring depth.
    logic [31:0]   len_full;
    logic [CW-1:0] len_w;

    assign len_full = (32'(chlen_reg) > 32'(WINDOW_DEPTH)) ? 32'(WINDOW_DEPTH)
                                                           : 32'(chlen_reg);
    assign len_w    = len_full[CW-1:0];

    // Ring bookkeeping and bar counter.
    logic [PW-1:0]  ptr_reg;
    logic [PW-1:0]  rp_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  k_reg;
    logic           seen0_reg;
    logic           seen_lt2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            rp_reg       <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            seen0_reg    <= 1'b0;
            seen_lt2_reg <= 1'b0;
        end
        else if (cmd.op == etbc_pkg::OP_LOAD)
        begin
            ptr_reg      <= (ptr_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            rp_reg       <= ptr_reg;
            k_reg        <= '0;
            seen0_reg    <= (count_reg == '0);
            seen_lt2_reg <= (count_reg < CW'(2));
            if (count_reg < CW'(WINDOW_DEPTH))
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
        else if (cmd.op == etbc_pkg::OP_WIN_ACC)
        begin
            rp_reg <= (rp_reg == '0) ? PW'(WINDOW_DEPTH - 1) : rp_reg - 1'b1;
            k_reg  <= k_reg + 1'b1;
        end
    end

    // Close ring memory.
    logic [CLW-1:0] ring_mem [WINDOW_DEPTH];
    logic [CLW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == etbc_pkg::OP_LOAD)
        begin
            ring_mem[ptr_reg] <= close_price;
        end
        if (cmd.op == etbc_pkg::OP_WIN_RD)
        begin
            rd_data_reg <= ring_mem[rp_reg];
        end
    end

    // Window sums and variance numerator.
    logic [2*CLW-1:0] sq_reg;
    logic [SMW-1:0]   sum_reg;
    logic [SQW-1:0]   sumsq_reg;
    logic [DVW-1:0]   m1_reg;
    logic [DVW-1:0]   m2_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            etbc_pkg::OP_LOAD:
            begin
                sum_reg   <= '0;
                sumsq_reg <= '0;
            end
            etbc_pkg::OP_WIN_SQ:
            begin
                sq_reg <= rd_data_reg * rd_data_reg;
            end
            etbc_pkg::OP_WIN_ACC:
            begin
                sum_reg   <= sum_reg + SMW'(rd_data_reg);
                sumsq_reg <= sumsq_reg + SQW'(sq_reg);
            end
            etbc_pkg::OP_VAR_MUL:
            begin
                m1_reg <= DVW'(len_w) * DVW'(sumsq_reg);
                m2_reg <= DVW'(sum_reg) * DVW'(sum_reg);
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    // Exponential averages and trend.
    logic [AW-1:0]      x_reg;
    logic [AW-1:0]      fast_reg;
    logic [AW-1:0]      slow_reg;
    logic [AW+15:0]     eprod_reg;
    logic               ege_reg;
    logic signed [AW:0] prev_reg;
    logic signed [AW+17:0] tprod_reg;
    logic signed [31:0] q_reg;

    logic               ema_slow;
    logic [AW-1:0]      ema_avg;
    logic [15:0]        ema_alpha;
    logic               ema_ge;
    logic [AW-1:0]      ema_dist;
    logic [AW-1:0]      ema_new;
    logic [AW+16:0]     ema_round;
    logic signed [AW:0]    diff_w;
    logic signed [AW+1:0]  delta_w;
    logic signed [AW+1:0]  q_wide;

    assign ema_slow  = (cmd.op == etbc_pkg::OP_EMA_S_MUL) || (cmd.op == etbc_pkg::OP_EMA_S_ADD);
    assign ema_avg   = ema_slow ? slow_reg : fast_reg;
    assign ema_alpha = ema_slow ? coef_reg[31:16] : coef_reg[15:0];
    assign ema_ge    = x_reg >= ema_avg;
    assign ema_dist  = ema_ge ? x_reg - ema_avg : ema_avg - x_reg;
    assign ema_round = {1'b0, eprod_reg} + (AW+17)'(16'hFFFF);
    assign ema_new   = seen0_reg ? x_reg
                     : ege_reg ? ema_avg + eprod_reg[AW+15:16]
                     : ema_avg - ema_round[AW+15:16];
    assign diff_w    = $signed({1'b0, fast_reg}) - $signed({1'b0, slow_reg});
    assign delta_w   = (AW+2)'(diff_w) - (AW+2)'(prev_reg);
    assign q_wide    = tprod_reg[AW+17:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg <= '0;
            slow_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                etbc_pkg::OP_EMA_F_ADD: fast_reg <= ema_new;
                etbc_pkg::OP_EMA_S_ADD: slow_reg <= ema_new;
                etbc_pkg::OP_DIFF:      prev_reg <= diff_w;
                default:                prev_reg <= prev_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            etbc_pkg::OP_LOAD:
            begin
                x_reg <= {close_price, 16'h0000};
            end
            etbc_pkg::OP_EMA_F_MUL, etbc_pkg::OP_EMA_S_MUL:
            begin
                eprod_reg <= ema_dist * ema_alpha;
                ege_reg   <= ema_ge;
            end
            etbc_pkg::OP_DIFF:
            begin
                tprod_reg <= delta_w * $signed({1'b0, sens_reg});
            end
            etbc_pkg::OP_TREND:
            begin
                // Saturate the floored trend to the signed 32-bit range.
                if (q_wide > (AW+2)'(32'sh7FFFFFFF))
                begin
                    q_reg <= 32'sh7FFFFFFF;
                end
                else if (q_wide < -(AW+2)'(64'sh80000000))
                begin
                    q_reg <= 32'sh80000000;
                end
                else
                begin
                    q_reg <= q_wide[31:0];
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    // Shared divider and square root unit.
    logic           it_start;
    logic           it_sqrt;
    logic [DVW-1:0] it_dividend;
    logic [DW-1:0]  it_divisor;
    logic           it_done;
    logic [DVW-1:0] it_quo;
    logic [etbc_pkg::ROOT_W-1:0] it_root;
    logic [DW-1:0]  den_reg;
    logic [31:0]    v_reg;
    logic [2*CW-1:0] len_sq;

    assign len_sq      = len_w * len_w;
    assign it_start    = (cmd.op == etbc_pkg::OP_VAR_START) || (cmd.op == etbc_pkg::OP_SQRT_START)
                      || (cmd.op == etbc_pkg::OP_BLEND_START);
    assign it_sqrt     = (cmd.op == etbc_pkg::OP_SQRT_START);
    assign it_dividend = (cmd.op == etbc_pkg::OP_VAR_START) ? m1_reg - m2_reg : DVW'(v_reg);
    assign it_divisor  = (cmd.op == etbc_pkg::OP_VAR_START) ? DW'(len_sq) : den_reg;

    etbc_iter #(
        .DVW (DVW)
    ) u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (it_start),
        .sqrt_mode (it_sqrt),
        .dividend  (it_dividend),
        .divisor   (it_divisor),
        .done      (it_done),
        .quotient  (it_quo),
        .root      (it_root)
    );

    // Band, classification and colour blend.
    logic                 win_ok;
    logic [31:0]          e1_reg;
    logic [35:0]          band_prod;
    logic [etbc_pkg::ROOT_W-1:0] sd_w;
    logic [2:0]           cls_reg;
    logic [23:0]          color_reg;
    logic                 blend_reg;
    logic [23:0]          num_reg;
    logic [23:0]          lo_reg;
    logic [23:0]          hi_reg;

    logic signed [32:0]   q_ext;
    logic [32:0]          mag;
    logic signed [34:0]   num_s;
    logic [23:0]          den_w;
    logic                 up;
    logic [47:0]          pair;
    logic [7:0]           lo_c;
    logic [7:0]           hi_c;
    logic [31:0]          lo_den;
    logic signed [8:0]    dc;
    logic signed [33:0]   pn;
    logic signed [33:0]   v_s;

    assign win_ok    = (len_w > CW'(1)) && (count_reg >= len_w);
    assign sd_w      = win_ok ? it_root : '0;
    assign band_prod = mult_reg * sd_w;

    assign q_ext = {q_reg[31], q_reg};
    assign mag   = q_reg[31] ? 33'(-q_ext) : 33'(q_ext);
    assign num_s = $signed({2'b00, mag}) - $signed({3'b000, e1_reg}) - 35'sd256;
    assign den_w = {top_reg - 16'd1, 8'h00};
    assign up    = !q_reg[31];
    assign pair  = up ? up_reg : down_reg;

    always_comb
    begin
        case (cmd.chan)
            2'd0:
            begin
                lo_c = lo_reg[23:16];
                hi_c = hi_reg[23:16];
            end
            2'd1:
            begin
                lo_c = lo_reg[15:8];
                hi_c = hi_reg[15:8];
            end
            default:
            begin
                lo_c = lo_reg[7:0];
                hi_c = hi_reg[7:0];
            end
        endcase
    end

    assign lo_den = lo_c * den_reg;
    assign dc     = $signed({1'b0, hi_c}) - $signed({1'b0, lo_c});
    assign pn     = $signed({1'b0, num_reg}) * dc;
    assign v_s    = $signed({2'b00, lo_den}) + pn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= 1'b0;
        end
        else if (cmd.op == etbc_pkg::OP_CLASS)
        begin
            blend_reg <= (q_reg != '0) && (mag > 33'(e1_reg)) && (top_reg > 16'd1)
                      && (num_s < $signed({11'b0, den_w})) && (num_s > 35'sd0);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            etbc_pkg::OP_BAND:
            begin
                e1_reg <= 32'(band_prod >> 7);
            end
            etbc_pkg::OP_CLASS:
            begin
                lo_reg  <= pair[23:0];
                hi_reg  <= pair[47:24];
                num_reg <= num_s[23:0];
                den_reg <= den_w;
                if (q_reg == '0)
                begin
                    cls_reg   <= etbc_pkg::TC_NONE;
                    color_reg <= etbc_pkg::COLOR_WHITE;
                end
                else if (mag <= 33'(e1_reg))
                begin
                    cls_reg   <= up ? etbc_pkg::TC_UP_WEAK : etbc_pkg::TC_DOWN_WEAK;
                    color_reg <= up ? weak_reg[23:0] : weak_reg[47:24];
                end
                else
                begin
                    cls_reg <= up ? etbc_pkg::TC_UP_STRONG : etbc_pkg::TC_DOWN_STRONG;
                    // Saturated strength takes the high colour, none the low one.
                    if ((top_reg <= 16'd1) || (num_s >= $signed({11'b0, den_w})))
                    begin
                        color_reg <= pair[47:24];
                    end
                    else
                    begin
                        color_reg <= pair[23:0];
                    end
                end
            end
            etbc_pkg::OP_BLEND_MUL:
            begin
                v_reg <= v_s[31:0];
            end
            etbc_pkg::OP_CH_STORE:
            begin
                case (cmd.chan)
                    2'd0:    color_reg[23:16] <= it_quo[7:0];
                    2'd1:    color_reg[15:8]  <= it_quo[7:0];
                    default: color_reg[7:0]   <= it_quo[7:0];
                endcase
            end
            default:
            begin
                e1_reg <= e1_reg;
            end
        endcase
    end

    // Output register.
    logic        out_valid_reg;
    logic        push;
    logic [23:0] out_color_reg;
    logic [2:0]  out_cls_reg;
    logic signed [31:0] out_q_reg;
    logic [31:0] out_e1_reg;

    assign push = (cmd.op == etbc_pkg::OP_PUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_color_reg <= color_reg;
            out_cls_reg   <= cls_reg;
            out_q_reg     <= q_reg;
            out_e1_reg    <= e1_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign red            = out_color_reg[23:16];
    assign green          = out_color_reg[15:8];
    assign blue           = out_color_reg[7:0];
    assign trend_class    = out_cls_reg;
    assign trend_value    = out_q_reg;
    assign explosion_band = out_e1_reg;

    // Status toward the controller.
    assign status.seen_lt2   = seen_lt2_reg;
    assign status.win_ok     = win_ok;
    assign status.win_last   = (k_reg == len_w - 1'b1);
    assign status.iter_done  = it_done;
    assign status.need_blend = blend_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // Checks.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ptr_reg) < WINDOW_DEPTH)
        else $error("ring pointer out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= WINDOW_DEPTH)
        else $error("bar count above window depth");

    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("pushed result not presented");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_cls_reg == etbc_pkg::TC_NONE)) |-> (out_q_reg == '0))
        else $error("no-trend class with nonzero trend");

endmodule

// ----- design/etbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etbc_ctrl
// Controller: sequences one bar through the datapath, one operation per
// cycle, and waits on the shared iterative unit and the output register.
// ----------------------------------------------------------------------------
module etbc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output etbc_pkg::dp_cmd_t     cmd,
    input  etbc_pkg::dp_status_t  status
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EMA_F_MUL,
        ST_EMA_F_ADD,
        ST_EMA_S_MUL,
        ST_EMA_S_ADD,
        ST_DIFF,
        ST_TREND,
        ST_WIN_RD,
        ST_WIN_SQ,
        ST_WIN_ACC,
        ST_VAR_MUL,
        ST_VAR_START,
        ST_VAR_WAIT,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_BAND,
        ST_CLASS,
        ST_BLEND_MUL,
        ST_BLEND_START,
        ST_BLEND_WAIT,
        ST_PUSH
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] chan_reg;
    logic [1:0] chan_next;
    etbc_pkg::dp_op_t op;

    // Next state and operation decode.
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        op         = etbc_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = etbc_pkg::OP_LOAD;
                    state_next = ST_EMA_F_MUL;
                end
            end
            ST_EMA_F_MUL:
            begin
                op         = etbc_pkg::OP_EMA_F_MUL;
                state_next = ST_EMA_F_ADD;
            end
            ST_EMA_F_ADD:
            begin
                op         = etbc_pkg::OP_EMA_F_ADD;
                state_next = ST_EMA_S_MUL;
            end
            ST_EMA_S_MUL:
            begin
                op         = etbc_pkg::OP_EMA_S_MUL;
                state_next = ST_EMA_S_ADD;
            end
            ST_EMA_S_ADD:
            begin
                op         = etbc_pkg::OP_EMA_S_ADD;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                op         = etbc_pkg::OP_DIFF;
                state_next = status.seen_lt2 ? ST_IDLE : ST_TREND;
            end
            ST_TREND:
            begin
                op         = etbc_pkg::OP_TREND;
                state_next = status.win_ok ? ST_WIN_RD : ST_BAND;
            end
            ST_WIN_RD:
            begin
                op         = etbc_pkg::OP_WIN_RD;
                state_next = ST_WIN_SQ;
            end
            ST_WIN_SQ:
            begin
                op         = etbc_pkg::OP_WIN_SQ;
                state_next = ST_WIN_ACC;
            end
            ST_WIN_ACC:
            begin
                op         = etbc_pkg::OP_WIN_ACC;
                state_next = status.win_last ? ST_VAR_MUL : ST_WIN_RD;
            end
            ST_VAR_MUL:
            begin
                op         = etbc_pkg::OP_VAR_MUL;
                state_next = ST_VAR_START;
            end
            ST_VAR_START:
            begin
                op         = etbc_pkg::OP_VAR_START;
                state_next = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:
            begin
                if (status.iter_done)
                begin
                    state_next = ST_SQRT_START;
                end
            end
            ST_SQRT_START:
            begin
                op         = etbc_pkg::OP_SQRT_START;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (status.iter_done)
                begin
                    state_next = ST_BAND;
                end
            end
            ST_BAND:
            begin
                op         = etbc_pkg::OP_BAND;
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                op         = etbc_pkg::OP_CLASS;
                state_next = ST_BLEND_MUL;
            end
            ST_BLEND_MUL:
            begin
                // Blending is decided by the class step just before.
                if (status.need_blend)
                begin
                    op         = etbc_pkg::OP_BLEND_MUL;
                    state_next = ST_BLEND_START;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_BLEND_START:
            begin
                op         = etbc_pkg::OP_BLEND_START;
                state_next = ST_BLEND_WAIT;
            end
            ST_BLEND_WAIT:
            begin
                if (status.iter_done)
                begin
                    op = etbc_pkg::OP_CH_STORE;
                    if (chan_reg == 2'd2)
                    begin
                        chan_next  = 2'd0;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 2'd1;
                        state_next = ST_BLEND_MUL;
                    end
                end
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    op         = etbc_pkg::OP_PUSH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and channel registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.op   = op;
    assign cmd.chan = chan_reg;

    // Checks.
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        chan_reg != 2'd3)
        else $error("blend channel out of range");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == etbc_pkg::OP_LOAD) |=> (state_reg == ST_EMA_F_MUL) && !in_ready)
        else $error("transaction accepted without leaving idle");

    a_chan_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (chan_reg == 2'd0))
        else $error("blend channel not rewound");

endmodule
